@@ sv/mtd_pkg.sv @@
package mtd_pkg;

  // Fixed width of the sample and median ports.
  localparam int SampleW = 10;

  localparam int DefWindowDepth = 6;
  localparam int DefTrendDepth  = 6;
  localparam int DefSampleBits  = 10;

endpackage

@@ sv/median_trend_detector_core.sv @@
// Median trend detector. Each item carries one converter sample; the block keeps the
// last WINDOW_DEPTH samples (zeros after reset) and returns, for every item, the upper
// median of that window, together with a trend flag that is set when the newest median
// is not below the median of TREND_DEPTH-1 items earlier and cleared otherwise. The
// comparison starts with item TREND_DEPTH+1 (compared is high from then on); before
// that the flag holds its reset value of zero. The block takes one item per clock
// cycle unless in_stall is raised. The sample is written into the window at
// acceptance, and once the result register is free the rank-select median network
// and the trend compare load it with the result. Stall on the output is absorbed by
// one holding stage, so input stall rises only while a finished result is stalled and
// another item is waiting behind it.
module median_trend_detector_core #(
  parameter int WINDOW_DEPTH = mtd_pkg::DefWindowDepth,
  parameter int TREND_DEPTH  = mtd_pkg::DefTrendDepth,
  parameter int SAMPLE_BITS  = mtd_pkg::DefSampleBits
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mtd_pkg::SampleW-1:0] sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mtd_pkg::SampleW-1:0] median_value,
  output logic                        block_flag,
  output logic                        compared
);

  localparam int StoreW = (SAMPLE_BITS < mtd_pkg::SampleW) ? SAMPLE_BITS : mtd_pkg::SampleW;
  localparam int FillW  = $clog2(TREND_DEPTH + 1);

  logic [StoreW-1:0] window [WINDOW_DEPTH];
  logic [StoreW-1:0] hist   [TREND_DEPTH-1];
  logic [StoreW-1:0] med;
  logic              held;
  logic [FillW-1:0]  fill_count;
  logic              blocked;
  logic              blocked_next;
  logic              out_free;
  logic              advance;
  logic              in_take;
  logic              full;

  assign out_free = !out_valid || !out_stall;
  assign advance  = held && out_free;
  assign in_stall = held && !out_free;
  assign in_take  = in_valid && !in_stall;
  assign full     = (fill_count == FillW'(TREND_DEPTH));

  mtd_median #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .STORE_W     (StoreW)
  ) u_median (
    .window(window),
    .median(med)
  );

  // The oldest median still in the ring is the one from TREND_DEPTH-1 items back.
  assign blocked_next = full ? (med >= hist[TREND_DEPTH-2]) : blocked;

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= 1'b0;
      out_valid  <= 1'b0;
      fill_count <= '0;
      blocked    <= 1'b0;
      for (int k = 0; k < WINDOW_DEPTH; k++) begin
        window[k] <= '0;
      end
    end else begin
      if (in_take) begin
        held <= 1'b1;
        window[0] <= sample[StoreW-1:0];
        for (int k = 1; k < WINDOW_DEPTH; k++) begin
          window[k] <= window[k-1];
        end
      end else if (advance) begin
        held <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        blocked   <= blocked_next;
        if (!full) begin
          fill_count <= fill_count + FillW'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hist[0] <= med;
      for (int k = 1; k < TREND_DEPTH - 1; k++) begin
        hist[k] <= hist[k-1];
      end
      median_value <= mtd_pkg::SampleW'(med);
      block_flag   <= blocked_next;
      compared     <= full;
    end
  end

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FillW'(TREND_DEPTH))
    else $error("fill count ran past the trend depth");

  a_flag_holds: assert property (@(posedge clk) disable iff (rst)
    advance && !full |=> $stable(blocked))
    else $error("trend flag changed before the median ring was full");

  a_compared_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && compared |-> full)
    else $error("comparison reported while the ring was not full");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> held && out_valid && out_stall)
    else $error("input stalled without a waiting item behind a stalled result");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && !held || out_valid && held)
    else $error("item left the window stage without reaching the result register");
`endif

endmodule

@@ sv/mtd_median.sv @@
module mtd_median #(
  parameter int WINDOW_DEPTH = mtd_pkg::DefWindowDepth,
  parameter int STORE_W      = mtd_pkg::SampleW
) (
  input  logic [STORE_W-1:0] window [WINDOW_DEPTH],
  output logic [STORE_W-1:0] median
);

  localparam int RankW = $clog2(WINDOW_DEPTH);
  localparam int Mid   = WINDOW_DEPTH / 2;

  // Each entry gets a stable rank: the number of entries that are smaller, or
  // equal and stored at a lower position. The ranks are therefore a permutation,
  // and the entry whose rank is the middle one is the upper median.
  logic [WINDOW_DEPTH-1:0] ahead [WINDOW_DEPTH];
  logic [RankW-1:0]        rank  [WINDOW_DEPTH];
  logic [STORE_W-1:0]      pick  [WINDOW_DEPTH];

  for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_rank
    for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_cmp
      if (j < i) begin : g_low
        assign ahead[i][j] = (window[j] <= window[i]);
      end else if (j > i) begin : g_high
        assign ahead[i][j] = (window[j] < window[i]);
      end else begin : g_self
        assign ahead[i][j] = 1'b0;
      end
    end
    assign rank[i] = RankW'($countones(ahead[i]));
    assign pick[i] = (rank[i] == RankW'(Mid)) ? window[i] : '0;
  end

  always_comb begin
    median = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      median = median | pick[i];
    end
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int SampleW      = mtd_pkg::SampleW;
  localparam int WIN          = mtd_pkg::DefWindowDepth;
  localparam int TREND        = mtd_pkg::DefTrendDepth;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES  = 60;

  typedef struct packed {
    logic [SampleW-1:0] median;
    logic               flag;
    logic               cmp;
  } trend_result_t;

  typedef struct packed {
    logic [SampleW-1:0] smp;
    bit                 known;
    trend_result_t      typed;
  } directed_row_t;

  typedef enum int {
    SHAPE_NOISE,
    SHAPE_RISE,
    SHAPE_FALL,
    SHAPE_FLAT,
    SHAPE_RAIL,
    SHAPE_JITTER
  } burst_shape_t;

  // The first rows start from the reset window of zeros, so their medians can be
  // read straight off; the rest go through the predictor.
  localparam int DIRECTED_LEN = 25;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
    '{10'd1023, 1'b1, '{10'd0,    1'b0, 1'b0}},
    '{10'd1023, 1'b1, '{10'd0,    1'b0, 1'b0}},
    '{10'd1023, 1'b1, '{10'd1023, 1'b0, 1'b0}},
    '{10'd0,    1'b0, '0},
    '{10'd0,    1'b0, '0},
    '{10'd0,    1'b0, '0},
    '{10'd0,    1'b0, '0},
    '{10'd512,  1'b0, '0},
    '{10'd600,  1'b0, '0},
    '{10'd700,  1'b0, '0},
    '{10'd800,  1'b0, '0},
    '{10'd900,  1'b0, '0},
    '{10'd1000, 1'b0, '0},
    '{10'd100,  1'b0, '0},
    '{10'd90,   1'b0, '0},
    '{10'd80,   1'b0, '0},
    '{10'd70,   1'b0, '0},
    '{10'd60,   1'b0, '0},
    '{10'd50,   1'b0, '0},
    '{10'd682,  1'b0, '0},
    '{10'd341,  1'b0, '0},
    '{10'd341,  1'b0, '0},
    '{10'd341,  1'b0, '0},
    '{10'd341,  1'b0, '0},
    '{10'd341,  1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [SampleW-1:0] sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [SampleW-1:0] median_value;
  logic               block_flag;
  logic               compared;

  median_trend_detector_core uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .median_value (median_value),
    .block_flag   (block_flag),
    .compared     (compared)
  );

  always #2 clk = ~clk;

  // Predictor state, mirroring the block from reset.
  logic [SampleW-1:0] sample_win [WIN]   = '{default: '0};
  logic [SampleW-1:0] median_ring [TREND] = '{default: '0};
  int                 win_pos = 0;
  int                 med_pos = 0;
  int                 fill_cnt = 0;
  logic               trend_blocked = 1'b0;

  trend_result_t expected_trend_q [$];
  int            mismatches = 0;
  int            items_in = 0;
  int            hold_left = 0;
  bit            held_once = 1'b0;
  bit            calm;

  // A quiet stretch in the middle of the run with no idling on either side.
  assign calm = (items_in >= 250) && (items_in < 350);

  function automatic logic [SampleW-1:0] window_upper_median();
    logic [SampleW-1:0] s [WIN];
    logic [SampleW-1:0] v;
    int                 j;
    s = sample_win;
    for (int i = 1; i < WIN; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[WIN/2];
  endfunction

  function automatic trend_result_t predict_trend(input logic [SampleW-1:0] smp);
    trend_result_t r;
    sample_win[win_pos] = smp;
    win_pos = (win_pos + 1) % WIN;
    r.median = window_upper_median();
    median_ring[med_pos] = r.median;
    med_pos = (med_pos + 1) % TREND;
    r.cmp = 1'b0;
    if (fill_cnt >= TREND) begin
      // After the write, med_pos points at the oldest median still held.
      trend_blocked = median_ring[(med_pos + TREND - 1) % TREND] >= median_ring[med_pos];
      r.cmp = 1'b1;
    end else begin
      fill_cnt++;
    end
    r.flag = trend_blocked;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_sample(input logic [SampleW-1:0] smp, input bit known,
                             input trend_result_t typed);
    trend_result_t r;
    while (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_trend(smp);
    expected_trend_q.push_back(known ? typed : r);
    items_in++;
  endtask

  task automatic check_result();
    trend_result_t e;
    if (expected_trend_q.size() == 0) begin
      report_mismatch($sformatf("result with none expected, median %0d", median_value));
    end else begin
      e = expected_trend_q.pop_front();
      if (median_value !== e.median)
        report_mismatch($sformatf("median_value %0d, expected %0d", median_value, e.median));
      if (block_flag !== e.flag)
        report_mismatch($sformatf("block_flag %b, expected %b", block_flag, e.flag));
      if (compared !== e.cmp)
        report_mismatch($sformatf("compared %b, expected %b", compared, e.cmp));
    end
  endtask

  // Result side: check what is accepted, then decide the stall for the next cycle.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_once && items_in >= 120) begin
        // Long hold-off so that the block fills and pushes back on its input.
        out_stall <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        held_once <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 24);
      end
    end
  end

  initial begin
    burst_shape_t shape;
    int           burst_len;
    int           level;
    int           step;
    int           random_done;
    random_done = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_LEN; i++)
      send_sample(DIRECTED_ROWS[i].smp, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].typed);

    // Bursts of shaped traffic so that the trend flag sees long rises, falls and plateaus.
    while (random_done < RANDOM_ITEMS) begin
      shape     = burst_shape_t'($urandom_range(5));
      burst_len = $urandom_range(14, 6);
      level     = $urandom_range(1023);
      step      = $urandom_range(40, 1);
      for (int k = 0; k < burst_len; k++) begin
        case (shape)
          SHAPE_NOISE: level = $urandom_range(1023);
          SHAPE_RISE:  level = (level + step > 1023) ? 1023 : level + step;
          SHAPE_FALL:  level = (level < step) ? 0 : level - step;
          SHAPE_RAIL:  level = $urandom_range(1) ? 1023 : 0;
          SHAPE_JITTER: begin
            level = level + int'($urandom_range(16)) - 8;
            if (level < 0) level = 0;
            else if (level > 1023) level = 1023;
          end
          default: ;
        endcase
        send_sample(level[SampleW-1:0], 1'b0, '0);
        random_done++;
      end
    end

    in_valid <= 1'b0;
    while (expected_trend_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
